>>> src/led_temporal_dither_packer_assert.svh
// Assertion macros used by the dither packer top-level source.
`ifndef LED_TEMPORAL_DITHER_PACKER_ASSERT_SVH
`define LED_TEMPORAL_DITHER_PACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LTDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltdp check failed");

// Next-cycle implication, checked outside reset.
`define LTDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltdp check failed");

`endif

>>> src/ltdp_pkg.sv
package ltdp_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_LEDS_DEF      = 64;
    localparam int RESIDUAL_BITS_DEF = 8;

    // Fixed field widths.
    localparam int LEVEL_W = 16;
    localparam int DEPTH_W = 5;
    localparam int COUNT_W = 7;
    localparam int GRB_W   = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 2'd1;

    // Bit depth limits and reset values.
    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 5'd8;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

endpackage

>>> src/ltdp_ram.sv
module ltdp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port with enable.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/ltdp_lane.sv
module ltdp_lane #(
    parameter int RES_BITS = 8
) (
    input  logic [ltdp_pkg::LEVEL_W-1:0] level,
    input  logic [ltdp_pkg::DEPTH_W-1:0] depth,
    input  logic [RES_BITS-1:0]          res_in,
    output logic [7:0]                   level8,
    output logic [RES_BITS-1:0]          res_out
);

    import ltdp_pkg::*;

    localparam int SUM_W = LEVEL_W + 1;

    logic [SUM_W-1:0] full;
    logic [SUM_W-1:0] sum_raw;
    logic [SUM_W-1:0] sum_clamped;
    logic [SUM_W-1:0] low_mask;
    logic [3:0]       shift;

    // Add the carried residual to the masked target and saturate at full scale.
    always_comb
    begin
        shift       = 4'(depth - DEPTH_MIN);
        full        = (SUM_W'(1) << depth) - SUM_W'(1);
        sum_raw     = ({1'b0, level} & full) + SUM_W'(res_in);
        sum_clamped = (sum_raw > full) ? full : sum_raw;
        low_mask    = (SUM_W'(1) << shift) - SUM_W'(1);
        level8      = 8'(sum_clamped >> shift);
        res_out     = RES_BITS'(sum_clamped & low_mask);
    end

endmodule

>>> src/led_temporal_dither_packer.sv
// Temporal dither packer for a chain of serial RGB LEDs.
// Input channel: in_valid/in_stall with red, green and blue targets and a
// lights_on flag, one LED per transaction in chain order. Output channel:
// out_valid/out_stall with the packed GRB word and a frame_end flag on the
// last LED of the chain. Configuration: cfg_valid/cfg_ready write channel;
// index 0 is bit_depth, index 1 is led_count; cfg_ready is always high.
// An accepted transaction passes through the read stage into the output
// register; one transaction per cycle is sustained while the receiver does
// not stall. The limit is the residual memory read, followed by the dither
// add, with a forward path when consecutive LEDs share an entry.
// After reset the residual memory is swept to zero, during which in_stall
// is held high; configuration writes are still taken.
// When the receiver stalls, the output register holds its result and one
// more transaction may enter the read stage behind it; after that in_stall
// rises until the output drains.
`include "led_temporal_dither_packer_assert.svh"

module led_temporal_dither_packer #(
    parameter int MAX_LEDS      = ltdp_pkg::MAX_LEDS_DEF,
    parameter int RESIDUAL_BITS = ltdp_pkg::RESIDUAL_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ltdp_pkg::LEVEL_W-1:0]     red_level,
    input  logic [ltdp_pkg::LEVEL_W-1:0]     green_level,
    input  logic [ltdp_pkg::LEVEL_W-1:0]     blue_level,
    input  logic                             lights_on,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ltdp_pkg::GRB_W-1:0]       grb_word,
    output logic                             frame_end,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ltdp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ltdp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import ltdp_pkg::*;

    localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int RB    = RESIDUAL_BITS;
    localparam int MEM_W = 3 * RB;
    localparam int CNT_W = ((COUNT_W > $clog2(MAX_LEDS + 1)) ? COUNT_W
                           : $clog2(MAX_LEDS + 1)) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);

    // Configuration registers.
    logic [DEPTH_W-1:0] bit_depth_reg;
    logic [COUNT_W-1:0] led_count_reg;

    // Clearing sweep.
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // Position counter.
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_eff;
    logic [AW-1:0] pos_next;
    logic          last;

    // Read stage.
    logic               s1_valid_reg;
    logic [AW-1:0]      s1_pos_reg;
    logic               s1_last_reg;
    logic               s1_on_reg;
    logic [LEVEL_W-1:0] s1_red_reg;
    logic [LEVEL_W-1:0] s1_green_reg;
    logic [LEVEL_W-1:0] s1_blue_reg;
    logic               s1_fwd_reg;
    logic [MEM_W-1:0]   s1_fwd_data_reg;

    // Output register.
    logic             out_valid_reg;
    logic [GRB_W-1:0] grb_word_reg;
    logic             frame_end_reg;

    logic               out_en;
    logic               s1_en;
    logic               acc;
    logic               fwd_match;
    logic [DEPTH_W-1:0] depth_eff;
    logic [CNT_W-1:0]   count_eff;
    logic [MEM_W-1:0]   ram_rdata;
    logic [MEM_W-1:0]   res_cur;
    logic [MEM_W-1:0]   res_new;
    logic [7:0]         red8;
    logic [7:0]         green8;
    logic [7:0]         blue8;
    logic               item_we;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [MEM_W-1:0]   ram_wdata;

    // Handshake and stage enables.
    assign out_en    = !out_valid_reg || !out_stall;
    assign s1_en     = !s1_valid_reg || out_en;
    assign in_stall  = !s1_en || clr_active_reg;
    assign acc       = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Effective configuration after range clamping.
    always_comb
    begin
        if (bit_depth_reg < DEPTH_MIN)
        begin
            depth_eff = DEPTH_MIN;
        end
        else if (bit_depth_reg > DEPTH_MAX)
        begin
            depth_eff = DEPTH_MAX;
        end
        else
        begin
            depth_eff = bit_depth_reg;
        end

        if (led_count_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (CNT_W'(led_count_reg) > CNT_W'(MAX_LEDS))
        begin
            count_eff = CNT_W'(MAX_LEDS);
        end
        else
        begin
            count_eff = CNT_W'(led_count_reg);
        end
    end

    // Current LED, last-LED flag and next position.
    always_comb
    begin
        pos_eff  = (32'(pos_reg) >= 32'(MAX_LEDS)) ? '0 : pos_reg;
        last     = (CNT_W'(pos_eff) + CNT_W'(1)) >= count_eff;
        pos_next = last ? '0 : AW'(pos_eff + AW'(1));
    end

    // The entry being written this cycle is forwarded to an item reading it.
    assign fwd_match = s1_valid_reg && s1_on_reg && (s1_pos_reg == pos_eff);

    // Residual memory: sweep writes during clearing, item writes afterwards.
    assign item_we   = s1_valid_reg && s1_on_reg && out_en;
    assign ram_we    = clr_active_reg || item_we;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_pos_reg;
    assign ram_wdata = clr_active_reg ? '0 : res_new;

    ltdp_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_LEDS)
    ) u_res_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s1_en),
        .raddr (pos_eff),
        .rdata (ram_rdata)
    );

    // Dither the three channels with the residual read for this LED.
    assign res_cur = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;

    ltdp_lane #(.RES_BITS(RB)) u_lane_red (
        .level   (s1_red_reg),
        .depth   (depth_eff),
        .res_in  (res_cur[3*RB-1:2*RB]),
        .level8  (red8),
        .res_out (res_new[3*RB-1:2*RB])
    );

    ltdp_lane #(.RES_BITS(RB)) u_lane_green (
        .level   (s1_green_reg),
        .depth   (depth_eff),
        .res_in  (res_cur[2*RB-1:RB]),
        .level8  (green8),
        .res_out (res_new[2*RB-1:RB])
    );

    ltdp_lane #(.RES_BITS(RB)) u_lane_blue (
        .level   (s1_blue_reg),
        .depth   (depth_eff),
        .res_in  (res_cur[RB-1:0]),
        .level8  (blue8),
        .res_out (res_new[RB-1:0])
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg <= DEPTH_MIN;
            led_count_reg <= COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BIT_DEPTH: bit_depth_reg <= cfg_data[DEPTH_W-1:0];
                REG_LED_COUNT: led_count_reg <= cfg_data[COUNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Clearing sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= AW'(clr_addr_reg + AW'(1));
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Position counter and stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                pos_reg <= pos_next;
            end
            if (s1_en)
            begin
                s1_valid_reg <= acc;
            end
            if (out_en)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Read stage payload.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pos_reg      <= pos_eff;
            s1_last_reg     <= last;
            s1_on_reg       <= lights_on;
            s1_red_reg      <= red_level;
            s1_green_reg    <= green_level;
            s1_blue_reg     <= blue_level;
            s1_fwd_reg      <= fwd_match;
            s1_fwd_data_reg <= res_new;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (out_en && s1_valid_reg)
        begin
            grb_word_reg  <= s1_on_reg ? {green8, red8, blue8} : '0;
            frame_end_reg <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign grb_word  = grb_word_reg;
    assign frame_end = frame_end_reg;

    // Checks.
    `LTDP_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, clr_active_reg, in_stall)
    `LTDP_ASSERT_NOW(a_full_blocks_input, clk, rst_n,
        s1_valid_reg && out_valid_reg && out_stall, in_stall)
    `LTDP_ASSERT_NOW(a_item_write_after_clear, clk, rst_n, item_we, !clr_active_reg)
    `LTDP_ASSERT_NEXT(a_last_wraps, clk, rst_n, acc && last, pos_reg == '0)

endmodule

>>> tb/sv/led_temporal_dither_packer_tb.sv
module led_temporal_dither_packer_tb;

    import ltdp_pkg::*;

    localparam int LED_SLOTS   = MAX_LEDS_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 120;
    localparam int ROWS        = 22;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [GRB_W-1:0] grb;
        logic             end_flag;
    } led_result_t;

    // One directed transaction, with the register settings it runs under.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] depth_set;
        logic [CFG_DATA_W-1:0] count_set;
        logic [LEVEL_W-1:0]    r;
        logic [LEVEL_W-1:0]    g;
        logic [LEVEL_W-1:0]    b;
        logic                  on;
        logic                  known;
        logic [GRB_W-1:0]      grb;
        logic                  end_flag;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [LEVEL_W-1:0]    red_level = '0;
    logic [LEVEL_W-1:0]    green_level = '0;
    logic [LEVEL_W-1:0]    blue_level = '0;
    logic                  lights_on = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [GRB_W-1:0]      grb_word;
    logic                  frame_end;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the block state used for prediction.
    logic [23:0]           residual_mem [LED_SLOTS];
    logic [DEPTH_W-1:0]    depth_reg = DEPTH_MIN;
    logic [COUNT_W-1:0]    count_reg = COUNT_RESET;
    int unsigned           led_pos = 0;

    led_result_t           pending_words [$];
    int                    error_count = 0;
    int                    quiet_cycles = 0;
    bit                    idle_on = 1'b1;

    dir_row_t directed_rows [ROWS] = '{
        '{7'd8,  7'd64,  16'hFFFF, 16'h0000, 16'h1234, 1'b1, 1'b1, 24'h00FF34, 1'b0},
        '{7'd8,  7'd64,  16'h0000, 16'hFFFF, 16'h00AB, 1'b1, 1'b1, 24'hFF00AB, 1'b0},
        '{7'd8,  7'd64,  16'h5555, 16'hAAAA, 16'hFFFF, 1'b0, 1'b1, 24'h000000, 1'b0},
        '{7'd8,  7'd64,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 24'h000000, 1'b0},
        '{7'd8,  7'd64,  16'h00FF, 16'h00FF, 16'h00FF, 1'b1, 1'b1, 24'hFFFFFF, 1'b0},
        '{7'd16, 7'd2,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 24'hFFFFFF, 1'b1},
        '{7'd16, 7'd2,   16'h00FF, 16'h0180, 16'h7F00, 1'b1, 1'b0, 24'h0, 1'b0},
        '{7'd16, 7'd2,   16'h1234, 16'hABCD, 16'h8000, 1'b1, 1'b0, 24'h0, 1'b0},
        '{7'd16, 7'd2,   16'hFFFF, 16'hFF80, 16'hFF01, 1'b1, 1'b0, 24'h0, 1'b0},
        '{7'd16, 7'd2,   16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 24'h000000, 1'b1},
        '{7'd16, 7'd2,   16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 24'h0, 1'b0},
        '{7'd0,  7'd0,   16'h01FF, 16'h02FE, 16'h0301, 1'b1, 1'b0, 24'h0, 1'b0},
        '{7'd0,  7'd0,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 24'h000000, 1'b1},
        '{7'd31, 7'd127, 16'hFFFF, 16'h8001, 16'h7FFF, 1'b1, 1'b0, 24'h0, 1'b0},
        '{7'd31, 7'd127, 16'hABCD, 16'h1234, 16'h5678, 1'b1, 1'b0, 24'h0, 1'b0},
        '{7'd12, 7'd3,   16'h0FFF, 16'h0800, 16'hF7FF, 1'b1, 1'b0, 24'h0, 1'b0},
        '{7'd12, 7'd3,   16'h0FFF, 16'h0FFF, 16'h0FFF, 1'b1, 1'b0, 24'h0, 1'b0},
        '{7'd12, 7'd3,   16'h0001, 16'h0002, 16'h0003, 1'b1, 1'b0, 24'h0, 1'b0},
        '{7'd12, 7'd3,   16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 24'h0, 1'b0},
        '{7'd9,  7'd3,   16'h01FF, 16'h0100, 16'h00FF, 1'b1, 1'b0, 24'h0, 1'b0},
        '{7'd9,  7'd3,   16'h0123, 16'h0155, 16'h01AA, 1'b0, 1'b0, 24'h0, 1'b0},
        '{7'd9,  7'd3,   16'h0155, 16'h00AA, 16'h01FF, 1'b1, 1'b0, 24'h0, 1'b0}
    };

    led_temporal_dither_packer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .lights_on   (lights_on),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .grb_word    (grb_word),
        .frame_end   (frame_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bit depth actually in force: out-of-range settings saturate to 8 or 16.
    function automatic int unsigned active_depth();
        if (depth_reg < DEPTH_MIN)
            return DEPTH_MIN;
        if (depth_reg > DEPTH_MAX)
            return DEPTH_MAX;
        return depth_reg;
    endfunction

    // Dither one channel: add the carried error, clamp, keep the shifted-out bits.
    function automatic logic [7:0] dither_lane(input logic [LEVEL_W-1:0] target,
                                               input int unsigned depth,
                                               inout logic [7:0] carry);
        int unsigned shift;
        int unsigned full;
        int unsigned sum;
        shift = depth - 8;
        full  = (1 << depth) - 1;
        sum   = (target & full) + carry;
        if (sum > full)
            sum = full;
        carry = 8'(sum & ((1 << shift) - 1));
        return 8'(sum >> shift);
    endfunction

    // Expected GRB word and frame flag for one LED; advances the shadow state.
    function automatic led_result_t dither_led(input logic [LEVEL_W-1:0] r,
                                               input logic [LEVEL_W-1:0] g,
                                               input logic [LEVEL_W-1:0] b,
                                               input logic on);
        led_result_t res;
        int unsigned count;
        int unsigned pos;
        int unsigned depth;
        logic [7:0]  cr, cg, cb, lr, lg, lb;
        count = count_reg;
        if (count < 1)
            count = 1;
        if (count > LED_SLOTS)
            count = LED_SLOTS;
        pos = led_pos;
        if (pos >= LED_SLOTS)
            pos = 0;
        res.end_flag = (pos + 1 >= count);
        res.grb = '0;
        if (on)
        begin
            depth = active_depth();
            {cr, cg, cb} = residual_mem[pos];
            lr = dither_lane(r, depth, cr);
            lg = dither_lane(g, depth, cg);
            lb = dither_lane(b, depth, cb);
            residual_mem[pos] = {cr, cg, cb};
            res.grb = {lg, lr, lb};
        end
        led_pos = res.end_flag ? 0 : pos + 1;
        return res;
    endfunction

    // Random channel target, weighted toward the clamp region and the extremes.
    function automatic logic [LEVEL_W-1:0] pick_level();
        int unsigned full;
        full = (1 << active_depth()) - 1;
        case ($urandom_range(5))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return LEVEL_W'((full - $urandom_range(3)) | ($urandom & ~full));
            3: return LEVEL_W'($urandom_range(3));
            default: return LEVEL_W'($urandom);
        endcase
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $time, what);
    endtask

    // Offer one transaction, wait for it to be taken, then record what it must produce.
    task automatic send_led(input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] g,
                            input logic [LEVEL_W-1:0] b, input logic on,
                            input logic known, input logic [GRB_W-1:0] grb,
                            input logic end_flag);
        led_result_t want;
        if (idle_on && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        red_level   <= r;
        green_level <= g;
        blue_level  <= b;
        lights_on   <= on;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = dither_led(r, g, b, on);
        if (known)
        begin
            want.grb      = grb;
            want.end_flag = end_flag;
        end
        pending_words.push_back(want);
    endtask

    task automatic drain_results();
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_BIT_DEPTH)
            depth_reg = val[DEPTH_W-1:0];
        else if (idx == REG_LED_COUNT)
            count_reg = val;
    endtask

    // Back-to-back register writes; valid drops only after the last one.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] depth_set,
                                input logic [CFG_DATA_W-1:0] count_set);
        cfg_write(REG_BIT_DEPTH, depth_set);
        cfg_write(REG_LED_COUNT, count_set);
        if ($urandom_range(3) == 0)
            cfg_write(REG_SPARE, CFG_DATA_W'($urandom_range(127)));
        cfg_valid <= 1'b0;
    endtask

    // Output side: compare each accepted transaction and, while idle_on is set, stall at random.
    always @(posedge clk)
    begin : result_check
        led_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                flag_error($sformatf("unexpected result grb_word=%06h frame_end=%0b",
                                     grb_word, frame_end));
            end
            else
            begin
                want = pending_words.pop_front();
                if (grb_word !== want.grb || frame_end !== want.end_flag)
                    flag_error($sformatf("mismatch grb_word exp %06h got %06h, frame_end exp %0b got %0b",
                                         want.grb, grb_word, want.end_flag, frame_end));
            end
        end
        out_stall <= idle_on && ($urandom_range(99) < 8);
    end

    // Watchdog: too long without any transaction on any channel ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] cur_depth;
        logic [CFG_DATA_W-1:0] cur_count;
        logic [CFG_DATA_W-1:0] d;
        logic [CFG_DATA_W-1:0] c;
        int                    k;
        int                    phase;

        foreach (residual_mem[i])
            residual_mem[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Registers are written during the clearing pass that follows reset.
        program_regs(7'd8, 7'd64);
        cur_depth = 7'd8;
        cur_count = 7'd64;

        // Directed part: extremes, lights off, position past a lowered count.
        for (k = 0; k < ROWS; k++)
        begin
            if (directed_rows[k].depth_set != cur_depth ||
                directed_rows[k].count_set != cur_count)
            begin
                in_valid <= 1'b0;
                drain_results();
                cur_depth = directed_rows[k].depth_set;
                cur_count = directed_rows[k].count_set;
                program_regs(cur_depth, cur_count);
            end
            send_led(directed_rows[k].r, directed_rows[k].g, directed_rows[k].b,
                     directed_rows[k].on, directed_rows[k].known,
                     directed_rows[k].grb, directed_rows[k].end_flag);
        end
        in_valid <= 1'b0;

        // Random part: one register setting per phase, extremes first.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin d = 7'd16; c = 7'd64; end
                1: begin d = 7'd8; c = 7'd1; end
                2: begin d = 7'd31; c = 7'd127; end
                3: begin d = 7'd0; c = 7'd0; end
                default:
                begin
                    d = CFG_DATA_W'(($urandom_range(1)) ? $urandom_range(8, 16)
                                                        : $urandom_range(127));
                    c = CFG_DATA_W'(($urandom_range(1)) ? $urandom_range(1, 6)
                                                        : $urandom_range(127));
                end
            endcase
            drain_results();
            program_regs(d, c);
            idle_on = (phase != 5);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // In phase 2, hold off once mid-phase until the output side has caught up.
                if (phase == 2 && k == PHASE_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    drain_results();
                end
                send_led(pick_level(), pick_level(), pick_level(),
                         $urandom_range(99) < 85, 1'b0, '0, 1'b0);
            end
            in_valid <= 1'b0;
        end
        idle_on = 1'b1;

        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_words.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
